### src/sps_pkg.sv
package sps_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int WINDOW_DEF      = 64;
    localparam int BASE_LIMIT_DEF  = 65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BCLR,
        ST_BSCAN_RD,
        ST_BSCAN_CHK,
        ST_BSTRIKE,
        ST_CHECK,
        ST_ROOT,
        ST_PRD,
        ST_PCHK,
        ST_DIV,
        ST_MARK,
        ST_DONE
    } state_t;

endpackage

### src/segmented_prime_sieve_unit.sv
// Segmented prime sieve. A request on start is taken while busy is low and
// answered by one done strobe carrying prime_mask and range_error; the result
// is shown for that single cycle only, since the receiver cannot stall. The
// first request after reset first clears and builds the base sieve in an
// internal one-bit memory of BASE_LIMIT entries: it clears every entry, then
// strikes the multiples of each base prime below the square root of
// BASE_LIMIT. Each request then takes a bit-serial integer square root of the
// high bound and, for every candidate up to the root, reads the memory; for
// each base prime it works out the remainder of the low bound in the divider,
// then strikes each multiple in the window and leaves the marking pass. The
// memory has a single read-modify-write port and the divider is bit-serial.
module segmented_prime_sieve_unit #(
    parameter int VALUE_WIDTH = sps_pkg::VALUE_WIDTH_DEF,
    parameter int WINDOW      = sps_pkg::WINDOW_DEF,
    parameter int BASE_LIMIT  = sps_pkg::BASE_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] low_bound,
    input  logic [31:0] high_bound,
    output logic        done,
    output logic [63:0] prime_mask,
    output logic        range_error
);
    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(BASE_LIMIT);
    localparam int PW = 21;
    localparam int RW = 22;

    sps_pkg::state_t state_reg, state_next;

    logic          mem [BASE_LIMIT];
    logic          rd_data_reg;
    logic [AW-1:0] addr;
    logic          wr_en;
    logic          wr_bit;

    logic          base_ready_reg;
    logic [AW:0]   bi_reg;
    logic [AW+1:0] bj_reg;
    logic [VW-1:0] lo_reg, hi_reg;
    logic [63:0]   marks_reg, window_marks_reg;
    logic [RW-1:0] root_reg, rbit_reg;
    logic [PW:0]   p_reg;
    logic [VW:0]   j_reg;
    logic [63:0]   out_mask_reg;
    logic          out_err_reg;
    logic          out_vld_reg;

    logic [PW-1:0] dv_r;
    logic          dv_done;
    logic          dv_start;

    logic [VW:0]   span;
    logic [2*RW-1:0] cand_sq;
    logic [RW-1:0] cand;
    logic [2*PW+1:0] psq;
    logic [VW:0]   first;
    logic [VW+1:0] jstart;

    assign span    = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;
    assign cand    = root_reg | rbit_reg;
    assign cand_sq = cand * cand;
    assign psq     = {{(PW+1){1'b0}}, p_reg} * {{(PW+1){1'b0}}, p_reg};
    // First multiple at or above low: low rounded up by p minus the remainder.
    assign first   = (dv_r == '0) ? {1'b0, lo_reg}
                   : {1'b0, lo_reg} + (VW+1)'(p_reg[PW-1:0] - dv_r);
    assign jstart  = ((VW+2)'(psq) > {1'b0, first}) ? (VW+2)'(psq)
                   : {1'b0, first};

    sps_divider #(.VW(VW), .PW(PW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (lo_reg),
        .divisor  (p_reg[PW-1:0]),
        .remainder(dv_r),
        .done     (dv_done)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= wr_bit;
        rd_data_reg <= mem[addr];
    end

    always_comb
    begin
        addr   = '0;
        wr_en  = 1'b0;
        wr_bit = 1'b1;
        case (state_reg)
            sps_pkg::ST_BCLR:
            begin
                addr   = bi_reg[AW-1:0];
                wr_en  = 1'b1;
                wr_bit = (bi_reg < (AW+1)'(2));
            end
            sps_pkg::ST_BSCAN_RD: addr = bi_reg[AW-1:0];
            sps_pkg::ST_BSTRIKE:
            begin
                addr  = bj_reg[AW-1:0];
                wr_en = (bj_reg < (AW+2)'(BASE_LIMIT));
            end
            sps_pkg::ST_PRD: addr = p_reg[AW-1:0];
            default: addr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        dv_start   = 1'b0;
        case (state_reg)
            sps_pkg::ST_IDLE:
                if (start)
                    state_next = base_ready_reg ? sps_pkg::ST_CHECK : sps_pkg::ST_BCLR;
            sps_pkg::ST_BCLR:
                if (bi_reg == (AW+1)'(BASE_LIMIT - 1))
                    state_next = sps_pkg::ST_BSCAN_RD;
            sps_pkg::ST_BSCAN_RD:
                if ({{(AW+2){1'b0}}, bi_reg} * {{(AW+2){1'b0}}, bi_reg}
                    >= (2*AW+3)'(BASE_LIMIT))
                    state_next = sps_pkg::ST_CHECK;
                else
                    state_next = sps_pkg::ST_BSCAN_CHK;
            sps_pkg::ST_BSCAN_CHK:
                state_next = rd_data_reg ? sps_pkg::ST_BSCAN_RD : sps_pkg::ST_BSTRIKE;
            sps_pkg::ST_BSTRIKE:
                if (bj_reg >= (AW+2)'(BASE_LIMIT))
                    state_next = sps_pkg::ST_BSCAN_RD;
            sps_pkg::ST_CHECK:
                if (hi_reg < lo_reg || span > (VW+1)'(WINDOW))
                    state_next = sps_pkg::ST_DONE;
                else
                    state_next = sps_pkg::ST_ROOT;
            sps_pkg::ST_ROOT:
                if (rbit_reg == '0)
                    state_next = ((root_reg >= RW'(BASE_LIMIT)) || (root_reg < RW'(2)))
                               ? sps_pkg::ST_DONE : sps_pkg::ST_PRD;
            sps_pkg::ST_PRD: state_next = sps_pkg::ST_PCHK;
            sps_pkg::ST_PCHK:
                if (rd_data_reg)
                    state_next = ((PW+1)'(root_reg) == p_reg) ? sps_pkg::ST_DONE
                               : sps_pkg::ST_PRD;
                else
                begin
                    dv_start   = 1'b1;
                    state_next = sps_pkg::ST_DIV;
                end
            sps_pkg::ST_DIV:
                if (dv_done)
                    state_next = sps_pkg::ST_MARK;
            sps_pkg::ST_MARK:
                if (j_reg > {1'b0, hi_reg})
                    state_next = ((PW+1)'(root_reg) == p_reg) ? sps_pkg::ST_DONE
                               : sps_pkg::ST_PRD;
            sps_pkg::ST_DONE: state_next = sps_pkg::ST_IDLE;
            default: state_next = sps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sps_pkg::ST_IDLE;
            base_ready_reg   <= 1'b0;
            out_vld_reg      <= 1'b0;
            window_marks_reg <= '1;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= 1'b0;
            if (state_reg == sps_pkg::ST_BSCAN_RD && state_next == sps_pkg::ST_CHECK)
                base_ready_reg <= 1'b1;
            if (state_reg == sps_pkg::ST_DONE)
            begin
                out_vld_reg <= 1'b1;
                if (!out_err_reg)
                    window_marks_reg <= marks_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sps_pkg::ST_IDLE:
            begin
                lo_reg <= VW'(low_bound);
                hi_reg <= VW'(high_bound);
                bi_reg <= '0;
            end
            sps_pkg::ST_BCLR:
                bi_reg <= (bi_reg == (AW+1)'(BASE_LIMIT - 1)) ? (AW+1)'(2) : bi_reg + 1'b1;
            sps_pkg::ST_BSCAN_CHK:
                if (rd_data_reg)
                    bi_reg <= bi_reg + 1'b1;
                else
                    bj_reg <= (AW+2)'({{(AW+2){1'b0}}, bi_reg} * {{(AW+2){1'b0}}, bi_reg});
            sps_pkg::ST_BSTRIKE:
                if (bj_reg >= (AW+2)'(BASE_LIMIT))
                    bi_reg <= bi_reg + 1'b1;
                else
                    bj_reg <= bj_reg + (AW+2)'(bi_reg);
            sps_pkg::ST_CHECK:
            begin
                out_err_reg <= 1'b1;
                out_mask_reg <= '0;
                root_reg <= '0;
                rbit_reg <= RW'(1) << (RW - 2);
                p_reg    <= (PW+1)'(2);
                for (int k = 0; k < 64; k++)
                    marks_reg[k] <= (k < WINDOW) && ((VW+1)'(k) < span)
                                  && ({1'b0, lo_reg} + (VW+1)'(k) >= (VW+1)'(2));
            end
            sps_pkg::ST_ROOT:
            begin
                if (rbit_reg != '0)
                begin
                    if (cand_sq <= (2*RW)'(hi_reg))
                        root_reg <= cand;
                    rbit_reg <= rbit_reg >> 1;
                end
                else if (root_reg < RW'(BASE_LIMIT))
                begin
                    out_err_reg <= 1'b0;
                    out_mask_reg <= marks_reg;
                end
            end
            sps_pkg::ST_PCHK:
                if (rd_data_reg)
                    p_reg <= p_reg + 1'b1;
            sps_pkg::ST_DIV:
                if (dv_done)
                    j_reg <= (jstart > {1'b0, {(VW+1){1'b1}}}) ? '1 : jstart[VW:0];
            sps_pkg::ST_MARK:
                if (j_reg > {1'b0, hi_reg})
                begin
                    p_reg <= p_reg + 1'b1;
                    out_mask_reg <= marks_reg;
                end
                else
                begin
                    marks_reg[6'(j_reg - {1'b0, lo_reg})] <= 1'b0;
                    out_mask_reg[6'(j_reg - {1'b0, lo_reg})] <= 1'b0;
                    j_reg <= j_reg + (VW+1)'(p_reg);
                end
            default: ;
        endcase
    end

    assign busy        = (state_reg != sps_pkg::ST_IDLE);
    assign done        = out_vld_reg;
    assign prime_mask  = out_vld_reg ? out_mask_reg : '0;
    assign range_error = out_vld_reg & out_err_reg;
endmodule

### src/sps_divider.sv
module sps_divider #(
    parameter int VW = sps_pkg::VALUE_WIDTH_DEF,
    parameter int PW = 21
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [VW-1:0]     dividend,
    input  logic [PW-1:0]     divisor,
    output logic [PW-1:0]     remainder,
    output logic              done
);
    localparam int CW = $clog2(VW + 1);

    logic [VW-1:0] quot_reg;
    logic [PW:0]   rem_reg;
    logic [PW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [PW:0]   trial;
    logic [PW+1:0] diff;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg[PW-1:0], quot_reg[VW-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[PW+1])
            begin
                rem_reg  <= diff[PW:0];
                quot_reg <= {quot_reg[VW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[VW-2:0], 1'b0};
            end
        end
    end

    assign remainder = rem_reg[PW-1:0];
    assign done      = done_reg;
endmodule

### src/sps_checker.sv
module sps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [63:0] prime_mask,
    input logic        range_error
);
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && range_error |-> prime_mask == '0)
        else $error("refused beat carries a mask");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request not taken");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");
endmodule

bind segmented_prime_sieve_unit sps_checker u_sps_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .prime_mask(prime_mask), .range_error(range_error)
);

### verif/segmented_prime_sieve_unit_tb.sv
module segmented_prime_sieve_unit_tb;

    typedef struct {
        logic [63:0] mask;
        logic        refused;
    } window_result_t;

    class prime_window_scoreboard;
        bit             composite[sps_pkg::BASE_LIMIT_DEF];
        window_result_t pending_windows[$];
        int             mismatches;
        int             windows_checked;
        int             windows_refused;

        function new();
            longint unsigned i;
            longint unsigned j;
            mismatches = 0;
            windows_checked = 0;
            windows_refused = 0;
            foreach (composite[n])
                composite[n] = 1'b0;
            composite[0] = 1'b1;
            composite[1] = 1'b1;
            for (i = 2; i * i < sps_pkg::BASE_LIMIT_DEF; i++)
            begin
                if (!composite[i])
                begin
                    for (j = i * i; j < sps_pkg::BASE_LIMIT_DEF; j += i)
                        composite[j] = 1'b1;
                end
            end
        endfunction

        // Works out the expected bitmap and refusal of one taken window and queues it.
        function void note_window(logic [31:0] lo, logic [31:0] hi);
            window_result_t  res;
            longint unsigned span;
            longint unsigned root;
            longint unsigned top;
            longint unsigned mid;
            longint unsigned p;
            longint unsigned first;
            longint unsigned j;
            longint unsigned k;
            res.mask = '0;
            res.refused = 1'b1;
            span = longint'(hi) - longint'(lo) + 1;
            if (hi >= lo && span <= sps_pkg::WINDOW_DEF)
            begin
                root = 0;
                top = 64'd1 << 21;
                while (top - root > 1)
                begin
                    mid = root + (top - root) / 2;
                    if (mid * mid <= hi)
                        root = mid;
                    else
                        top = mid;
                end
                if (root < sps_pkg::BASE_LIMIT_DEF)
                begin
                    res.refused = 1'b0;
                    res.mask = (span >= 64) ? '1 : ((64'd1 << span) - 1);
                    for (k = 0; k < span; k++)
                    begin
                        if (lo + k < 2)
                            res.mask[k] = 1'b0;
                    end
                    for (p = 2; p <= root; p++)
                    begin
                        if (!composite[p])
                        begin
                            first = ((lo + p - 1) / p) * p;
                            j = (first > p * p) ? first : p * p;
                            for (; j <= hi; j += p)
                                res.mask[(j - lo) & 63] = 1'b0;
                        end
                    end
                end
            end
            pending_windows.insert(pending_windows.size(), res);
        endfunction

        function void check_window(logic [63:0] mask, logic refused);
            window_result_t want;
            if (pending_windows.size() == 0)
            begin
                $display("%0t: unexpected result mask=%h range_error=%b",
                         $time, mask, refused);
                mismatches++;
                return;
            end
            want = pending_windows.pop_front();
            windows_checked++;
            if (want.refused)
                windows_refused++;
            if (mask !== want.mask)
            begin
                $display("%0t: prime_mask expected %h actual %h",
                         $time, want.mask, mask);
                mismatches++;
            end
            if (refused !== want.refused)
            begin
                $display("%0t: range_error expected %b actual %b",
                         $time, want.refused, refused);
                mismatches++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    logic        done;
    logic [63:0] prime_mask;
    logic        range_error;

    prime_window_scoreboard windows;
    int  idle_cycles;
    int  burst_left;

    segmented_prime_sieve_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .low_bound   (low_bound),
        .high_bound  (high_bound),
        .done        (done),
        .prime_mask  (prime_mask),
        .range_error (range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                windows.note_window(low_bound, high_bound);
            if (done)
                windows.check_window(prime_mask, range_error);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_window(logic [31:0] lo, logic [31:0] hi);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        start = 1'b1;
        low_bound = lo;
        high_bound = hi;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_window();
        logic [31:0] hi;
        logic [31:0] span;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // Refused windows are cheap, so these carry the wide bit patterns.
            hi = $urandom();
            if ($urandom_range(0, 1) == 0)
                send_window(hi + $urandom_range(1, 1000), hi);
            else
                send_window($urandom(), $urandom());
        end
        else
        begin
            hi = (pick < 93) ? $urandom_range(0, 65535) : $urandom_range(0, 16777215);
            span = $urandom_range(1, 64);
            if ($urandom_range(0, 3) == 0)
                span = 64;
            if (span > hi + 1)
                span = hi + 1;
            send_window(hi - span + 1, hi);
        end
    endtask

    initial
    begin
        windows = new();
        rst_n = 1'b0;
        start = 1'b0;
        low_bound = '0;
        high_bound = '0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_window(32'd0, 32'd0);
        send_window(32'd0, 32'd1);
        send_window(32'd1, 32'd1);
        send_window(32'd2, 32'd2);
        send_window(32'd0, 32'd63);
        send_window(32'd0, 32'd64);
        send_window(32'd5, 32'd4);
        send_window(32'hFFFF_FFFF, 32'd0);
        send_window(32'd0, 32'hFFFF_FFFF);
        send_window(32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_window(32'd100, 32'd163);
        send_window(32'd120, 32'd127);
        send_window(32'd65500, 32'd65563);
        send_window(32'd1000000, 32'd1000063);
        send_window(32'hFFFF_FFC0, 32'hFFFF_FFFF);
        repeat (90)
            send_random_window();
        start = 1'b0;

        while (windows.pending_windows.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        $display("Checked %0d windows, %0d of them refused, prime bitmaps up to 2^32.",
                 windows.windows_checked, windows.windows_refused);
        if (windows.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
